[rtl/tsh_pkg.sv]
// Shared types and constants for the tape sensor hysteresis event block.
// No dependencies; every module of the block imports this package.
package tsh_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int SENSOR_COUNT = 7;
   localparam int CSR_W        = 10;
   localparam int CMP_W        = (SAMPLE_BITS > CSR_W) ? SAMPLE_BITS : CSR_W;
   localparam int QUEUE_DEPTH  = 2;

   // thresholds keep only the bits a sample can carry
   localparam logic [CSR_W-1:0] THR_MASK =
      (SAMPLE_BITS >= CSR_W) ? {CSR_W{1'b1}} : CSR_W'((1 << SAMPLE_BITS) - 1);

   localparam logic [CSR_W-1:0] ENTER_RESET = 10'd600 & THR_MASK;
   localparam logic [CSR_W-1:0] EXIT_RESET  = 10'd400 & THR_MASK;
   localparam logic [2:0]       WIDE_RESET  = 3'd3;

   // register indexes
   localparam logic [1:0] CSR_ENTER = 2'd0;
   localparam logic [1:0] CSR_EXIT  = 2'd1;
   localparam logic [1:0] CSR_WIDE  = 2'd2;

   // event codes
   localparam logic [3:0] EV_CHANGED  = 4'd0;
   localparam logic [3:0] EV_LOST     = 4'd1;
   localparam logic [3:0] EV_SENSOR0  = 4'd2;
   localparam logic [3:0] EV_WIDE     = 4'd9;
   localparam logic [3:0] EV_FCROSS   = 4'd10;
   localparam logic [3:0] EV_ALLBLACK = 4'd11;
   localparam logic [3:0] EV_RCROSS   = 4'd12;

   localparam logic [4:0] FRONT_ALL = 5'h1F;

   typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_vec_type;

   typedef struct packed {
      logic [CSR_W-1:0] enter_thr;
      logic [CSR_W-1:0] exit_thr;
      logic [2:0]       wide_min;
   } cfg_type;

   // one classified poll: the new mask and which optional events apply
   typedef struct packed {
      logic [SENSOR_COUNT-1:0] mask;
      logic                    lost;
      logic [2:0]              sensor_idx;
      logic                    wide;
      logic                    all_black;
      logic                    rear_cross;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/tsh_front.sv]
// Front end: accepts polls, applies hysteresis to the stored tape mask and
// classifies a change into a descriptor. Depends on tsh_pkg.
module tsh_front
   import tsh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  sample_vec_type   samples,
   input  queue_status_type q_status,
   output logic             push,
   output desc_type         push_desc
);

   logic [SENSOR_COUNT-1:0] mask_ff, mask_in;
   logic [SENSOR_COUNT-1:0] new_mask, changed;
   logic [2:0]              low_idx;
   logic                    found;
   logic [2:0]              pop_old, pop_new;
   logic                    accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      new_mask = mask_ff;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (mask_ff[i]) begin
            if (CMP_W'(samples[i]) < CMP_W'(cfg.exit_thr)) new_mask[i] = 1'b0;
         end else if (CMP_W'(samples[i]) > CMP_W'(cfg.enter_thr)) begin
            new_mask[i] = 1'b1;
         end
      end
   end

   assign changed = new_mask ^ mask_ff;

   always_comb begin
      low_idx = '0;
      found   = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (changed[i] && !found) begin
            low_idx = 3'(i);
            found   = 1'b1;
         end
      end
   end

   always_comb begin
      pop_old = '0;
      pop_new = '0;
      for (int i = 0; i < 5; i++) begin
         pop_old = pop_old + {2'b00, mask_ff[i]};
         pop_new = pop_new + {2'b00, new_mask[i]};
      end
   end

   always_comb begin
      push_desc.mask       = new_mask;
      push_desc.lost       = (new_mask == '0);
      push_desc.sensor_idx = low_idx;
      push_desc.wide       = (new_mask != '0) && (pop_old < cfg.wide_min)
                             && (pop_new >= cfg.wide_min);
      push_desc.all_black  = (new_mask != '0) && (mask_ff[4:0] != FRONT_ALL)
                             && (new_mask[4:0] == FRONT_ALL);
      push_desc.rear_cross = (new_mask != '0) && (mask_ff[6:5] == 2'b00)
                             && (new_mask[6:5] != 2'b00);
   end

   assign push    = accept && found;
   assign mask_in = push ? new_mask : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

endmodule

[rtl/tsh_queue.sv]
// Short descriptor queue between the front and back ends.
// Depends on tsh_pkg for the descriptor type and depth.
module tsh_queue
   import tsh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output desc_type         head,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[rtl/tsh_back.sv]
// Back end: takes descriptors from the queue and emits their events one per
// transfer, in order, flagging the final one. Depends on tsh_pkg.
module tsh_back
   import tsh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  desc_type         head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [3:0]       rsp_event_code,
   output logic [9:0]       rsp_event_param,
   output logic             rsp_last
);

   // pending event bits, lowest goes out first
   localparam int P_CHANGED  = 0;
   localparam int P_LOST     = 1;
   localparam int P_SENSOR   = 2;
   localparam int P_WIDE     = 3;
   localparam int P_FCROSS   = 4;
   localparam int P_ALLBLACK = 5;
   localparam int P_RCROSS   = 6;

   logic [6:0]              pend_ff, pend_in, rest, load_bits;
   logic [SENSOR_COUNT-1:0] mask_ff, mask_in;
   logic [2:0]              idx_ff, idx_in;
   logic                    xfer, need_load;

   assign rest      = pend_ff & (pend_ff - 7'd1);
   assign rsp_valid = (pend_ff != '0);
   assign rsp_last  = (rest == '0);
   assign xfer      = rsp_valid && !rsp_stall;
   assign need_load = !rsp_valid || (xfer && rsp_last);
   assign pop       = need_load && !q_status.empty;

   always_comb begin
      load_bits             = '0;
      load_bits[P_CHANGED]  = 1'b1;
      load_bits[P_LOST]     = head.lost;
      load_bits[P_SENSOR]   = !head.lost;
      load_bits[P_WIDE]     = head.wide;
      load_bits[P_FCROSS]   = head.wide;
      load_bits[P_ALLBLACK] = head.all_black;
      load_bits[P_RCROSS]   = head.rear_cross;
   end

   always_comb begin
      pend_in = pend_ff;
      mask_in = mask_ff;
      idx_in  = idx_ff;
      if (pop) begin
         pend_in = load_bits;
         mask_in = head.mask;
         idx_in  = head.sensor_idx;
      end else if (xfer) begin
         pend_in = rest;
      end
   end

   always_comb begin
      if (pend_ff[P_CHANGED]) begin
         rsp_event_code  = EV_CHANGED;
         rsp_event_param = {mask_ff[6:5], 3'b000, mask_ff[4:0]};
      end else if (pend_ff[P_LOST]) begin
         rsp_event_code  = EV_LOST;
         rsp_event_param = '0;
      end else if (pend_ff[P_SENSOR]) begin
         rsp_event_code  = EV_SENSOR0 + {1'b0, idx_ff};
         rsp_event_param = {3'b000, mask_ff};
      end else if (pend_ff[P_WIDE]) begin
         rsp_event_code  = EV_WIDE;
         rsp_event_param = {5'b00000, mask_ff[4:0]};
      end else if (pend_ff[P_FCROSS]) begin
         rsp_event_code  = EV_FCROSS;
         rsp_event_param = {5'b00000, mask_ff[4:0]};
      end else if (pend_ff[P_ALLBLACK]) begin
         rsp_event_code  = EV_ALLBLACK;
         rsp_event_param = {5'b00000, mask_ff[4:0]};
      end else begin
         rsp_event_code  = EV_RCROSS;
         rsp_event_param = {8'h00, mask_ff[6:5]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      idx_ff  <= idx_in;
   end

endmodule

[rtl/tape_sensor_hysteresis_events.sv]
// Top level of the tape sensor hysteresis event block: configuration
// registers and the front end, queue and back end. Depends on tsh_pkg.
//
// A poll is taken in the cycle it arrives; the front end updates the tape mask
// at once, so a new poll can follow every cycle while the two-entry queue has
// room. A poll that changes the mask yields two to six events, sent one per
// cycle by the back end while rsp_stall is low, so the back end sets the
// sustained rate at one event per cycle; polls that leave the mask alone cost
// nothing downstream. A poll's first event is presented once its descriptor
// has gone through the queue into the pending register. Configuration writes
// take effect at the next clock edge; writes to an unknown index are dropped.
module tape_sensor_hysteresis_events
   import tsh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_front_left,
   input  logic [SAMPLE_BITS-1:0] req_front_left_mid,
   input  logic [SAMPLE_BITS-1:0] req_front_mid,
   input  logic [SAMPLE_BITS-1:0] req_front_right_mid,
   input  logic [SAMPLE_BITS-1:0] req_front_right,
   input  logic [SAMPLE_BITS-1:0] req_rear_left,
   input  logic [SAMPLE_BITS-1:0] req_rear_right,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_event_code,
   output logic [9:0]             rsp_event_param,
   output logic                   rsp_last
);

   cfg_type          cfg_ff, cfg_in;
   sample_vec_type   samples;
   queue_status_type q_status;
   desc_type         push_desc, head;
   logic             push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ENTER: cfg_in.enter_thr = csr_wdata & THR_MASK;
            CSR_EXIT:  cfg_in.exit_thr  = csr_wdata & THR_MASK;
            CSR_WIDE:  cfg_in.wide_min  = csr_wdata[2:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_thr <= ENTER_RESET;
         cfg_ff.exit_thr  <= EXIT_RESET;
         cfg_ff.wide_min  <= WIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign samples[0] = req_front_left;
   assign samples[1] = req_front_left_mid;
   assign samples[2] = req_front_mid;
   assign samples[3] = req_front_right_mid;
   assign samples[4] = req_front_right;
   assign samples[5] = req_rear_left;
   assign samples[6] = req_rear_right;

   tsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .samples   (samples),
      .q_status  (q_status),
      .push      (push),
      .push_desc (push_desc)
   );

   tsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   tsh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_param (rsp_event_param),
      .rsp_last        (rsp_last)
   );

   // tape lost always closes a poll's events
   a_lost_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_LOST) |-> rsp_last)
      else $error("tape lost event not marked last");

   // mask changed is always followed by at least one more event
   a_changed_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_CHANGED) |-> !rsp_last)
      else $error("mask changed event marked last");

   // after a non-final transfer the next event of the same poll is presented
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
         && (rsp_event_code != EV_CHANGED))
      else $error("event burst broken");

endmodule

[bench/tape_sensor_hysteresis_events_test.sv]
// Self-checking bench for the tape sensor hysteresis event block: a directed
// table of polls and register writes, then random phases under random stalls.
// Depends on tsh_pkg and the tape_sensor_hysteresis_events top level.
module tape_sensor_hysteresis_events_test;
   import tsh_pkg::*;

   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
   localparam int SETTLE_CYCLES   = 8;
   localparam int QUIET_LIMIT     = 2000;
   localparam int RAND_PHASES     = 8;
   localparam int POLLS_PER_PHASE = 37;

   // no register sits here; writes to it must be dropped
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [3:0] code;
      logic [9:0] param;
      logic       last;
   } tape_event_type;

   typedef struct {
      logic           is_cfg;
      sample_vec_type smp;
      logic [9:0]     enter_v;
      logic [9:0]     exit_v;
      logic [2:0]     wide_v;
      int             n_typed;   // -1: left to the hysteresis tracker
      tape_event_type evs [6];
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [1:0]             csr_index = CSR_ENTER;
   logic [CSR_W-1:0]       csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_front_left = '0;
   logic [SAMPLE_BITS-1:0] req_front_left_mid = '0;
   logic [SAMPLE_BITS-1:0] req_front_mid = '0;
   logic [SAMPLE_BITS-1:0] req_front_right_mid = '0;
   logic [SAMPLE_BITS-1:0] req_front_right = '0;
   logic [SAMPLE_BITS-1:0] req_rear_left = '0;
   logic [SAMPLE_BITS-1:0] req_rear_right = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [3:0]             rsp_event_code;
   logic [9:0]             rsp_event_param;
   logic                   rsp_last;

   // tracker copy of the block's registers and mask
   logic [CSR_W-1:0]        enter_level = ENTER_RESET;
   logic [CSR_W-1:0]        exit_level  = EXIT_RESET;
   logic [2:0]              wide_min    = WIDE_RESET;
   logic [SENSOR_COUNT-1:0] mask_seen   = '0;

   tape_event_type poll_events [$];
   tape_event_type due_events [$];
   script_row_type script [$];

   bit calm = 1'b0;
   bit valid_up = 1'b0;
   int fail_count = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   tape_sensor_hysteresis_events u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_front_left      (req_front_left),
      .req_front_left_mid  (req_front_left_mid),
      .req_front_mid       (req_front_mid),
      .req_front_right_mid (req_front_right_mid),
      .req_front_right     (req_front_right),
      .req_rear_left       (req_rear_left),
      .req_rear_right      (req_rear_right),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_code      (rsp_event_code),
      .rsp_event_param     (rsp_event_param),
      .rsp_last            (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic tape_event_type ev(input logic [3:0] code, input logic [9:0] param,
                                         input logic last);
      tape_event_type e;
      e.code  = code;
      e.param = param;
      e.last  = last;
      return e;
   endfunction

   // Hysteresis against the old mask, then the ordered event list of one poll.
   function automatic void track_poll_events(input sample_vec_type s);
      logic [SENSOR_COUNT-1:0] old_m;
      logic [SENSOR_COUNT-1:0] new_m;
      logic [SENSOR_COUNT-1:0] flips;
      logic [4:0]              old_f;
      logic [4:0]              new_f;
      logic [1:0]              old_r;
      logic [1:0]              new_r;
      bit                      found;
      tape_event_type          tail;
      poll_events.delete();
      old_m = mask_seen;
      new_m = old_m;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (old_m[i]) begin
            if (s[i] < exit_level) new_m[i] = 1'b0;
         end else if (s[i] > enter_level) begin
            new_m[i] = 1'b1;
         end
      end
      if (new_m == old_m) return;
      mask_seen = new_m;
      flips = old_m ^ new_m;
      old_f = old_m[4:0];
      new_f = new_m[4:0];
      old_r = old_m[6:5];
      new_r = new_m[6:5];
      poll_events.push_back(ev(EV_CHANGED, {new_r, 3'b000, new_f}, 1'b0));
      if (new_m == '0) begin
         poll_events.push_back(ev(EV_LOST, '0, 1'b0));
      end else begin
         found = 1'b0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (flips[i] && !found) begin
               poll_events.push_back(ev(4'(EV_SENSOR0 + i), 10'(new_m), 1'b0));
               found = 1'b1;
            end
         end
         if ($countones(old_f) < wide_min && $countones(new_f) >= wide_min) begin
            poll_events.push_back(ev(EV_WIDE, 10'(new_f), 1'b0));
            poll_events.push_back(ev(EV_FCROSS, 10'(new_f), 1'b0));
         end
         if (old_f != FRONT_ALL && new_f == FRONT_ALL)
            poll_events.push_back(ev(EV_ALLBLACK, 10'(new_f), 1'b0));
         if (old_r == '0 && new_r != '0)
            poll_events.push_back(ev(EV_RCROSS, 10'(new_r), 1'b0));
      end
      tail = poll_events.pop_back();
      tail.last = 1'b1;
      poll_events.push_back(tail);
   endfunction

   function automatic sample_vec_type all_at(input int v);
      return {SENSOR_COUNT{SAMPLE_BITS'(v)}};
   endfunction

   function automatic sample_vec_type one_at(input int idx, input int v);
      sample_vec_type s;
      s = '0;
      s[idx] = SAMPLE_BITS'(v);
      return s;
   endfunction

   function automatic void add_poll(input sample_vec_type s, input int n = -1,
                                    input tape_event_type e0 = '0, input tape_event_type e1 = '0,
                                    input tape_event_type e2 = '0, input tape_event_type e3 = '0,
                                    input tape_event_type e4 = '0, input tape_event_type e5 = '0);
      script_row_type r;
      r.is_cfg  = 1'b0;
      r.smp     = s;
      r.enter_v = '0;
      r.exit_v  = '0;
      r.wide_v  = '0;
      r.n_typed = n;
      r.evs[0]  = e0;
      r.evs[1]  = e1;
      r.evs[2]  = e2;
      r.evs[3]  = e3;
      r.evs[4]  = e4;
      r.evs[5]  = e5;
      script.push_back(r);
   endfunction

   function automatic void add_cfg(input int en, input int ex, input int wm);
      script_row_type r;
      r.is_cfg  = 1'b1;
      r.smp     = '0;
      r.enter_v = 10'(en);
      r.exit_v  = 10'(ex);
      r.wide_v  = 3'(wm);
      r.n_typed = -1;
      for (int j = 0; j < 6; j++) r.evs[j] = '0;
      script.push_back(r);
   endfunction

   // mostly short gaps, now and then a long one; none at all in calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] level_above();
      if (int'(enter_level) >= SAMPLE_MAX) return '1;
      return SAMPLE_BITS'($urandom_range(int'(enter_level) + 1, SAMPLE_MAX));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] level_below();
      if (exit_level == '0) return '0;
      return SAMPLE_BITS'($urandom_range(0, int'(exit_level) - 1));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2: return level_above();
         3, 4, 5: return level_below();
         6:       return enter_level;
         7:       return exit_level;
         8:       return $urandom_range(0, 1) ? '1 : '0;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // whole-bar sweeps on or off tape drive the wide, all-black and lost paths
   function automatic sample_vec_type random_poll();
      sample_vec_type s;
      int             style;
      style = $urandom_range(0, 9);
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         case (style)
            0:       s[i] = level_above();
            1:       s[i] = level_below();
            default: s[i] = pick_sample();
         endcase
      end
      return s;
   endfunction

   function automatic logic [CSR_W-1:0] pick_level();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? '1 : '0;
      return CSR_W'($urandom_range(0, SAMPLE_MAX));
   endfunction

   task automatic send_poll(input sample_vec_type s, input int row);
      int gap;
      gap = pick_gap();
      if (gap > 0 && valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_valid           <= 1'b1;
      valid_up            = 1'b1;
      req_front_left      <= s[0];
      req_front_left_mid  <= s[1];
      req_front_mid       <= s[2];
      req_front_right_mid <= s[3];
      req_front_right     <= s[4];
      req_rear_left       <= s[5];
      req_rear_right      <= s[6];
      do @(posedge clock); while (req_stall);
      track_poll_events(s);
      if (row >= 0 && script[row].n_typed >= 0) begin
         for (int j = 0; j < script[row].n_typed; j++) due_events.push_back(script[row].evs[j]);
      end else begin
         foreach (poll_events[j]) due_events.push_back(poll_events[j]);
      end
   endtask

   // hold off until every event is out, then let stray no-event polls drain
   task automatic settle();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_W-1:0] en, input logic [CSR_W-1:0] ex,
                               input logic [2:0] wm);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ENTER;
      csr_wdata <= en;
      @(posedge clock);
      enter_level = en & THR_MASK;
      csr_index <= CSR_EXIT;
      csr_wdata <= ex;
      @(posedge clock);
      exit_level = ex & THR_MASK;
      // upper bits are junk the register must not keep
      csr_index <= CSR_WIDE;
      csr_wdata <= {7'($urandom), wm};
      @(posedge clock);
      wide_min = wm;
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      tape_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_events.size() == 0) begin
            $error("unexpected event: code %0d param 0x%0h last %0d",
                   rsp_event_code, rsp_event_param, rsp_last);
            fail_count++;
         end else begin
            want = due_events.pop_front();
            if (rsp_event_code !== want.code) begin
               $error("event_code: expected %0d, got %0d", want.code, rsp_event_code);
               fail_count++;
            end
            if (rsp_event_param !== want.param) begin
               $error("event_param: expected 0x%0h, got 0x%0h", want.param, rsp_event_param);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm) hold_cycles = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      // after reset, thresholds 600 / 400, wide count 3, mask clear
      add_poll(all_at(0), 0);
      add_poll(all_at(600), 0);
      add_poll(all_at(SAMPLE_MAX), 6,
               ev(EV_CHANGED, 10'h31F, 1'b0), ev(EV_SENSOR0, 10'h07F, 1'b0),
               ev(EV_WIDE, 10'h01F, 1'b0), ev(EV_FCROSS, 10'h01F, 1'b0),
               ev(EV_ALLBLACK, 10'h01F, 1'b0), ev(EV_RCROSS, 10'h003, 1'b1));
      add_poll(all_at(400), 0);
      add_poll(all_at(0), 2, ev(EV_CHANGED, '0, 1'b0), ev(EV_LOST, '0, 1'b1));
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         add_poll(one_at(i, SAMPLE_MAX));
         add_poll(all_at(0));
      end
      // wide count zero: old mask always meets it
      add_cfg(0, SAMPLE_MAX, 0);
      add_poll(all_at(1));
      add_poll(all_at(SAMPLE_MAX), 0);
      add_poll(all_at(SAMPLE_MAX - 1));
      add_cfg(SAMPLE_MAX, 0, 7);
      add_poll(all_at(SAMPLE_MAX), 0);
      // wide count above five can never be reached
      add_cfg(500, 500, 6);
      add_poll(all_at(501));
      add_poll(all_at(499));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_cfg) begin
            settle();
            write_config(script[k].enter_v, script[k].exit_v, script[k].wide_v);
         end else begin
            send_poll(script[k].smp, k);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         case (ph)
            1:       write_config('0, '1, 3'd0);
            2:       write_config('1, '0, 3'd7);
            default: write_config(pick_level(), pick_level(), 3'($urandom_range(0, 7)));
         endcase
         calm = (ph % 3 == 0);
         for (int n = 0; n < POLLS_PER_PHASE; n++) send_poll(random_poll(), -1);
      end
      calm = 1'b0;
      settle();

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/tsh_pkg.sv
rtl/tsh_front.sv
rtl/tsh_queue.sv
rtl/tsh_back.sv
rtl/tape_sensor_hysteresis_events.sv
bench/tape_sensor_hysteresis_events_test.sv
